### src/rgbd_pkg.sv
// shared types, constants and codes of the run-length glyph decoder
package rgbd_pkg;

  // defaults of the top level parameters
  localparam int MAX_FIELD_BITS_DEF = 8;
  localparam int COORD_BITS_DEF     = 16;

  // results that one data byte may produce, more are dropped
  localparam int MAX_RESULTS = 16;

  // depth of the token queue between front and back
  localparam int FIFO_DEPTH = 4;

  // configuration port
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int FIELD_CFG_W = 4;

  // row wrap divider widths
  localparam int WRAP_NUM_W = 9;
  localparam int WRAP_DEN_W = 8;

  // bytes dropped at the head of a record, the flagged one included
  localparam logic [1:0] SKIP_BYTES = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RUN_BITS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_RUN_BITS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BITS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BITS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_BITS     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YOFF_BITS     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_BITS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HINT_MODE     = 4'd7;

  // result kinds
  localparam logic [1:0] KIND_BG  = 2'd0;
  localparam logic [1:0] KIND_FG  = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  typedef enum logic [3:0] {
    PH_W, PH_H, PH_X, PH_Y, PH_D, PH_A, PH_B, PH_REP, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_RESOLVE, BK_RUN, BK_WRAP, BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        glyph_start;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [15:0]       box_x;
    logic [15:0]       box_y;
    logic [7:0]        glyph_w;
    logic [7:0]        start_x;
    logic [7:0]        start_y;
    logic [7:0]        run_length;
    logic signed [7:0] advance;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [FIELD_CFG_W-1:0] zero_run_bits;
    logic [FIELD_CFG_W-1:0] one_run_bits;
    logic [FIELD_CFG_W-1:0] width_bits;
    logic [FIELD_CFG_W-1:0] height_bits;
    logic [FIELD_CFG_W-1:0] xoff_bits;
    logic [FIELD_CFG_W-1:0] yoff_bits;
    logic [FIELD_CFG_W-1:0] advance_bits;
    logic                   hint_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zero_run_bits: 4'd4,
    one_run_bits:  4'd4,
    width_bits:    4'd5,
    height_bits:   4'd5,
    xoff_bits:     4'd4,
    yoff_bits:     4'd4,
    advance_bits:  4'd5,
    hint_mode:     1'b0
  };

  // queue token: a record start carrying the origin, or one data byte
  typedef struct packed {
    logic        is_start;
    logic [7:0]  data_byte;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } tok_t;

  typedef struct packed {
    logic    push;
    tok_t    tok;
  } push_t;

  typedef struct packed {
    logic [WRAP_NUM_W-1:0] rows;
    logic [WRAP_DEN_W-1:0] col;
  } wrap_res_t;

endpackage

### src/rgbd_front.sv
// front end: takes input beats, drops header bytes, queues start and data tokens
module rgbd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbd_pkg::in_item_t in_item,
  input  logic               q_full,
  output rgbd_pkg::push_t    q_push
);
  import rgbd_pkg::*;

  logic [1:0] skip_left_r, skip_left_nxt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    skip_left_nxt          = skip_left_r;
    q_push.push            = 1'b0;
    q_push.tok.is_start    = in_item.glyph_start;
    q_push.tok.data_byte   = in_item.data_byte;
    q_push.tok.origin_x    = in_item.origin_x;
    q_push.tok.origin_y    = in_item.origin_y;
    if (accept) begin
      if (in_item.glyph_start) begin
        // flagged byte is the first skipped one
        q_push.push   = 1'b1;
        skip_left_nxt = SKIP_BYTES - 2'd1;
      end else if (skip_left_r != 2'd0) begin
        skip_left_nxt = skip_left_r - 2'd1;
      end else begin
        q_push.push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_left_r <= SKIP_BYTES;
    end else begin
      skip_left_r <= skip_left_nxt;
    end
  end

endmodule

### src/rgbd_fifo.sv
// small token queue between front and back
module rgbd_fifo #(
  parameter int DEPTH = rgbd_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rgbd_pkg::push_t q_push,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rgbd_pkg::tok_t  head
);
  import rgbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.tok;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("token queue count past depth");

endmodule

### src/rgbd_wrap.sv
// iterative row wrap: quotient and remainder of column sum by glyph width
module rgbd_wrap (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rgbd_pkg::WRAP_NUM_W-1:0]     num,
  input  logic [rgbd_pkg::WRAP_DEN_W-1:0]     den,
  output logic                                done,
  output rgbd_pkg::wrap_res_t                 res
);
  import rgbd_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [WRAP_DEN_W-1:0] den_r, den_nxt;
  logic [WRAP_DEN_W-1:0] rem_r, rem_nxt;
  logic [WRAP_NUM_W-1:0] quo_r, quo_nxt;
  logic [WRAP_NUM_W-1:0] r2;
  logic                  ge;

  assign done     = done_r;
  assign res.rows = quo_r;
  assign res.col  = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    r2       = {rem_r, quo_r[WRAP_NUM_W-1]};
    ge       = (r2 >= {1'b0, den_r});
    if (start) begin
      den_nxt = den;
      if (num < {1'b0, den}) begin
        // stays in the row
        rem_nxt  = WRAP_DEN_W'(num);
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = '0;
        quo_nxt  = num;
        cnt_nxt  = 4'(WRAP_NUM_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // one quotient bit a cycle, restoring
      quo_nxt = {quo_r[WRAP_NUM_W-2:0], ge};
      rem_nxt = ge ? WRAP_DEN_W'(r2 - {1'b0, den_r}) : WRAP_DEN_W'(r2);
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

endmodule

### src/rgbd_back.sv
// back end: bit reader, header fields, run pairs and the result register
module rgbd_back #(
  parameter int MAX_FIELD_BITS = rgbd_pkg::MAX_FIELD_BITS_DEF,
  parameter int COORD_BITS     = rgbd_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbd_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  rgbd_pkg::tok_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rgbd_pkg::out_item_t out_item
);
  import rgbd_pkg::*;

  localparam int FILL_W = $clog2(MAX_FIELD_BITS + 1);
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  bk_state_t                state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [MAX_FIELD_BITS-1:0] accum_r, accum_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic [7:0]               zero_run_r, zero_run_nxt;
  logic [7:0]               one_run_r, one_run_nxt;
  logic [7:0]               pos_x_r, pos_x_nxt;
  logic [7:0]               pos_y_r, pos_y_nxt;
  logic [7:0]               width_r, width_nxt;
  logic [7:0]               height_r, height_nxt;
  logic [7:0]               adv_r, adv_nxt;
  logic [COORD_BITS-1:0]    box_x_r, box_x_nxt;
  logic [COORD_BITS-1:0]    box_y_r, box_y_nxt;
  logic [7:0]               byte_r, byte_nxt;
  logic [3:0]               bit_idx_r, bit_idx_nxt;
  logic [CNT_W-1:0]         res_cnt_r, res_cnt_nxt;
  logic                     run_fg_r, run_fg_nxt;
  logic [7:0]               run_len_r, run_len_nxt;
  logic                     rep_pend_r, rep_pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic [FIELD_CFG_W-1:0]    need_raw;
  logic [FILL_W-1:0]         need;
  logic [MAX_FIELD_BITS-1:0] fmask;
  logic [7:0]                half8, v8, off8;
  logic                      out_free, room, run_live, run_show;
  logic [9:0]                row_sum;
  out_item_t                 emit_item;

  logic                  wr_start, wr_done;
  logic [WRAP_NUM_W-1:0] wr_num;
  wrap_res_t             wr_res;

  rgbd_wrap u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wr_start),
    .num   (wr_num),
    .den   (width_r),
    .done  (wr_done),
    .res   (wr_res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;
  assign room      = res_cnt_r < CNT_W'(MAX_RESULTS);
  assign run_live  = (run_len_r != 8'd0) && (width_r != 8'd0);
  assign run_show  = run_fg_r || cfg.hint_mode;
  assign wr_num    = WRAP_NUM_W'(pos_x_r) + WRAP_NUM_W'(run_len_r);
  assign row_sum   = 10'(pos_y_r) + 10'(wr_res.rows);

  // field width of the current phase, clamped
  always_comb begin
    case (phase_r)
      PH_W:    need_raw = cfg.width_bits;
      PH_H:    need_raw = cfg.height_bits;
      PH_X:    need_raw = cfg.xoff_bits;
      PH_Y:    need_raw = cfg.yoff_bits;
      PH_D:    need_raw = cfg.advance_bits;
      PH_A:    need_raw = cfg.zero_run_bits;
      PH_B:    need_raw = cfg.one_run_bits;
      default: need_raw = FIELD_CFG_W'(1);
    endcase
    need = (need_raw > FIELD_CFG_W'(MAX_FIELD_BITS)) ? FILL_W'(MAX_FIELD_BITS)
                                                      : FILL_W'(need_raw);
    for (int k = 0; k < MAX_FIELD_BITS; k++) begin
      fmask[k] = (k < int'(need));
    end
    for (int k = 0; k < 8; k++) begin
      half8[k] = (int'(need) == k + 1);
    end
    v8   = 8'(accum_r & fmask);
    off8 = v8 - half8;
  end

  always_comb begin
    emit_item.box_x   = 16'(box_x_r);
    emit_item.box_y   = 16'(box_y_r);
    emit_item.glyph_w = width_r;
    if (state_r == BK_FIN) begin
      emit_item.kind       = KIND_END;
      emit_item.start_x    = 8'd0;
      emit_item.start_y    = 8'd0;
      emit_item.run_length = 8'd0;
      emit_item.advance    = adv_r;
      emit_item.last       = 1'b1;
    end else begin
      emit_item.kind       = run_fg_r ? KIND_FG : KIND_BG;
      emit_item.start_x    = pos_x_r;
      emit_item.start_y    = pos_y_r;
      emit_item.run_length = run_len_r;
      emit_item.advance    = 8'sd0;
      emit_item.last       = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    fill_nxt      = fill_r;
    zero_run_nxt  = zero_run_r;
    one_run_nxt   = one_run_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    adv_nxt       = adv_r;
    box_x_nxt     = box_x_r;
    box_y_nxt     = box_y_r;
    byte_nxt      = byte_r;
    bit_idx_nxt   = bit_idx_r;
    res_cnt_nxt   = res_cnt_r;
    run_fg_nxt    = run_fg_r;
    run_len_nxt   = run_len_r;
    rep_pend_nxt  = rep_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    wr_start      = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.is_start) begin
            box_x_nxt = COORD_BITS'(q_head.origin_x);
            box_y_nxt = COORD_BITS'(q_head.origin_y);
            phase_nxt = PH_W;
            accum_nxt = '0;
            fill_nxt  = '0;
          end else begin
            byte_nxt    = q_head.data_byte;
            bit_idx_nxt = 4'd0;
            res_cnt_nxt = '0;
            state_nxt   = BK_RESOLVE;
          end
        end
      end

      BK_RESOLVE: begin
        if (phase_r == PH_DONE) begin
          state_nxt = BK_IDLE;
        end else if (fill_r < need) begin
          if (bit_idx_r == 4'd8) begin
            state_nxt = BK_IDLE;
          end else begin
            for (int k = 0; k < MAX_FIELD_BITS; k++) begin
              if (int'(fill_r) == k) begin
                accum_nxt[k] = byte_r[bit_idx_r[2:0]];
              end
            end
            fill_nxt    = fill_r + 1'b1;
            bit_idx_nxt = bit_idx_r + 4'd1;
          end
        end else begin
          accum_nxt = '0;
          fill_nxt  = '0;
          case (phase_r)
            PH_W: begin
              width_nxt = v8;
              phase_nxt = PH_H;
            end
            PH_H: begin
              height_nxt = v8;
              box_y_nxt  = box_y_r - COORD_BITS'(v8);
              phase_nxt  = PH_X;
            end
            PH_X: begin
              box_x_nxt = box_x_r + COORD_BITS'(v8) - COORD_BITS'(half8);
              phase_nxt = PH_Y;
            end
            PH_Y: begin
              box_y_nxt = box_y_r - COORD_BITS'(v8) + COORD_BITS'(half8);
              phase_nxt = PH_D;
            end
            PH_D: begin
              adv_nxt   = off8;
              pos_x_nxt = 8'd0;
              pos_y_nxt = 8'd0;
              if (width_r == 8'd0) begin
                phase_nxt = PH_DONE;
                state_nxt = BK_FIN;
              end else begin
                phase_nxt = PH_A;
              end
            end
            PH_A: begin
              zero_run_nxt = v8;
              run_fg_nxt   = 1'b0;
              run_len_nxt  = v8;
              phase_nxt    = PH_B;
              state_nxt    = BK_RUN;
            end
            PH_B: begin
              one_run_nxt = v8;
              run_fg_nxt  = 1'b1;
              run_len_nxt = v8;
              phase_nxt   = PH_REP;
              state_nxt   = BK_RUN;
            end
            PH_REP: begin
              if (v8 != 8'd0) begin
                // replay the pair, foreground run queued behind
                run_fg_nxt   = 1'b0;
                run_len_nxt  = zero_run_r;
                rep_pend_nxt = 1'b1;
                state_nxt    = BK_RUN;
              end else if (pos_y_r >= height_r) begin
                phase_nxt = PH_DONE;
                state_nxt = BK_FIN;
              end else begin
                phase_nxt = PH_A;
              end
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end

      BK_RUN: begin
        if (!run_live) begin
          if (rep_pend_r) begin
            run_fg_nxt   = 1'b1;
            run_len_nxt  = one_run_r;
            rep_pend_nxt = 1'b0;
          end else begin
            state_nxt = BK_RESOLVE;
          end
        end else if (!(run_show && room && !out_free)) begin
          if (run_show && room) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = emit_item;
            res_cnt_nxt   = res_cnt_r + 1'b1;
          end
          wr_start  = 1'b1;
          state_nxt = BK_WRAP;
        end
      end

      BK_WRAP: begin
        if (wr_done) begin
          pos_x_nxt = wr_res.col;
          pos_y_nxt = (row_sum > 10'd255) ? 8'd255 : row_sum[7:0];
          if (rep_pend_r) begin
            run_fg_nxt   = 1'b1;
            run_len_nxt  = one_run_r;
            rep_pend_nxt = 1'b0;
            state_nxt    = BK_RUN;
          end else begin
            state_nxt = BK_RESOLVE;
          end
        end
      end

      BK_FIN: begin
        if (!room) begin
          state_nxt = BK_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = emit_item;
          res_cnt_nxt   = res_cnt_r + 1'b1;
          state_nxt     = BK_IDLE;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      phase_r     <= PH_W;
      accum_r     <= '0;
      fill_r      <= '0;
      zero_run_r  <= '0;
      one_run_r   <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      width_r     <= '0;
      height_r    <= '0;
      adv_r       <= '0;
      box_x_r     <= '0;
      box_y_r     <= '0;
      bit_idx_r   <= '0;
      res_cnt_r   <= '0;
      rep_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      fill_r      <= fill_nxt;
      zero_run_r  <= zero_run_nxt;
      one_run_r   <= one_run_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      adv_r       <= adv_nxt;
      box_x_r     <= box_x_nxt;
      box_y_r     <= box_y_nxt;
      bit_idx_r   <= bit_idx_nxt;
      res_cnt_r   <= res_cnt_nxt;
      rep_pend_r  <= rep_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    run_fg_r   <= run_fg_nxt;
    run_len_r  <= run_len_nxt;
    out_item_r <= out_item_nxt;
  end

  a_res_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count past limit");

  a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN || state_r == BK_WRAP) |-> (phase_r == PH_B || phase_r == PH_REP))
    else $error("run handled outside run phases");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RESOLVE && (phase_r == PH_A || phase_r == PH_B || phase_r == PH_REP))
      |-> (pos_x_r < width_r))
    else $error("column not inside glyph width");

  a_wrap_done: assert property (@(posedge clk) disable iff (!rst_n)
    wr_done |-> (state_r == BK_WRAP))
    else $error("row wrap finished with nobody waiting");

endmodule

### src/rle_glyph_bitstream_decoder.sv
// top level of the run-length glyph bitmap decoder
//
// in channel: one record byte per beat (in_valid/in_ready). the beat with
// glyph_start set carries the origin and is dropped together with the beat
// after it; later beats feed an lsb-first bit reader. the front end takes a
// beat every cycle while the four-entry token queue has room.
// out channel: one run or glyph end per beat (out_valid/out_ready), through
// a single output register that can be refilled in the cycle it is taken.
// cfg channel: field widths and hint mode, index 0..7, always ready; write
// only while the decoder is idle.
// back end work per data byte: the bits are taken in one at a time, each
// field is completed, and every emitted or skipped run goes to the row wrap,
// which skips the division when the run stays in its row and divides bit by
// bit when it crosses a row; then the end beat. dropped header beats never
// reach the back end. a run's out beat is loaded into the output register
// from the run state once its field completes, waiting while that is full.
// reset: registers back to defaults, origin and header state cleared, the
// next two beats are dropped as a header when no glyph start comes.
// a stalled receiver holds the output register, the back end waits, the
// queue fills and in_ready falls.
module rle_glyph_bitstream_decoder #(
  parameter int MAX_FIELD_BITS = rgbd_pkg::MAX_FIELD_BITS_DEF,
  parameter int COORD_BITS     = rgbd_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rgbd_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rgbd_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rgbd_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  push_t q_push;
  logic  q_full, q_empty, q_pop;
  tok_t  q_head;

  // register file: writes to unused indexes are ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZERO_RUN_BITS: cfg_nxt.zero_run_bits = cfg_data;
        CFG_ONE_RUN_BITS:  cfg_nxt.one_run_bits  = cfg_data;
        CFG_WIDTH_BITS:    cfg_nxt.width_bits    = cfg_data;
        CFG_HEIGHT_BITS:   cfg_nxt.height_bits   = cfg_data;
        CFG_XOFF_BITS:     cfg_nxt.xoff_bits     = cfg_data;
        CFG_YOFF_BITS:     cfg_nxt.yoff_bits     = cfg_data;
        CFG_ADVANCE_BITS:  cfg_nxt.advance_bits  = cfg_data;
        CFG_HINT_MODE:     cfg_nxt.hint_mode     = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: classify beats into start and data tokens
  rgbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  // queue decouples input stalls from decode stalls
  rgbd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  // back: bit reader, header decode, runs with row wrap, output register
  rgbd_back #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .COORD_BITS     (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### tb/testbench.sv
// self-checking bench for the run-length glyph decoder against a bit-level mirror
`timescale 1ns / 1ps

module testbench;
  import rgbd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  // worst back end cost per byte times the bytes that may sit in the token queue
  localparam int DRAIN_PAUSE  = 1200;
  localparam int PHASE_BEATS  = 12;
  localparam int PHASE_COUNT  = 8;
  localparam int MAX_STEPS    = 24;
  localparam int REPORT_LIMIT = 10;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  rle_glyph_bitstream_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // handshakes seen at the last rising edge, read by the falling-edge drivers
  bit in_fired, out_fired, cfg_fired;

  in_item_t  record_bytes[$];
  out_item_t due_results[$];
  bit        bitstream[$];

  int beats_queued, beats_taken, record_beats;
  int in_idle_pct, out_stall_pct;
  int error_count, cycle_count;

  // decoder mirror: register copy and decode state, reset values
  cfg_t        cfg_q = CFG_RESET;
  phase_t      ph = PH_W;
  bit          hdr_skip = 1'b1;
  int          skip_cnt, fill, col_q, row_q, beat_results;
  logic [7:0]  acc = '0;
  logic [7:0]  bg_len_q = '0, fg_len_q = '0, width_q = '0, height_q = '0, advance_q = '0;
  logic [15:0] box_x_q = '0, box_y_q = '0;

  function automatic int field_len(input logic [FIELD_CFG_W-1:0] v);
    return (v > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : int'(v);
  endfunction

  function automatic int field_need();
    case (ph)
      PH_W:    return field_len(cfg_q.width_bits);
      PH_H:    return field_len(cfg_q.height_bits);
      PH_X:    return field_len(cfg_q.xoff_bits);
      PH_Y:    return field_len(cfg_q.yoff_bits);
      PH_D:    return field_len(cfg_q.advance_bits);
      PH_A:    return field_len(cfg_q.zero_run_bits);
      PH_B:    return field_len(cfg_q.one_run_bits);
      default: return 1;
    endcase
  endfunction

  // one result of the current byte, beyond the per-byte cap it is dropped
  task automatic post_result(input logic [1:0] kind, input int sx, input int sy,
                             input logic [7:0] len, input logic [7:0] adv, input logic last);
    out_item_t r;
    if (beat_results >= MAX_RESULTS) return;
    r.kind       = kind;
    r.box_x      = box_x_q;
    r.box_y      = box_y_q;
    r.glyph_w    = width_q;
    r.start_x    = 8'(sx);
    r.start_y    = 8'(sy);
    r.run_length = len;
    r.advance    = adv;
    r.last       = last;
    due_results.push_back(r);
    beat_results++;
  endtask

  task automatic take_run(input logic [1:0] kind, input logic [7:0] len);
    int total;
    if (len == 0 || width_q == 0) return;
    if (kind == KIND_FG || cfg_q.hint_mode) post_result(kind, col_q, row_q, len, 8'd0, 1'b0);
    total = col_q + int'(len);
    row_q = row_q + total / int'(width_q);
    if (row_q > 255) row_q = 255;
    col_q = total % int'(width_q);
  endtask

  task automatic close_glyph();
    post_result(KIND_END, 0, 0, 8'd0, advance_q, 1'b1);
    ph = PH_DONE;
  endtask

  // complete every field that holds enough bits
  task automatic settle_fields();
    int n, half;
    logic [7:0] v;
    while (!hdr_skip && ph != PH_DONE && fill >= field_need()) begin
      n = field_need();
      v = acc & 8'((16'd1 << n) - 16'd1);
      half = (n == 0) ? 0 : (1 << (n - 1));
      acc = '0;
      fill = 0;
      case (ph)
        PH_W: begin
          width_q = v;
          ph = PH_H;
        end
        PH_H: begin
          height_q = v;
          box_y_q = box_y_q - 16'(v);
          ph = PH_X;
        end
        PH_X: begin
          box_x_q = box_x_q + 16'(v) - 16'(half);
          ph = PH_Y;
        end
        PH_Y: begin
          box_y_q = box_y_q - 16'(v) + 16'(half);
          ph = PH_D;
        end
        PH_D: begin
          advance_q = 8'(int'(v) - half);
          col_q = 0;
          row_q = 0;
          if (width_q == 0) close_glyph();
          else ph = PH_A;
        end
        PH_A: begin
          bg_len_q = v;
          take_run(KIND_BG, v);
          ph = PH_B;
        end
        PH_B: begin
          fg_len_q = v;
          take_run(KIND_FG, v);
          ph = PH_REP;
        end
        default: begin
          // repeat bit: replay the pair, end the glyph, or read a new pair
          if (v != 0) begin
            take_run(KIND_BG, bg_len_q);
            take_run(KIND_FG, fg_len_q);
          end else if (row_q >= int'(height_q)) begin
            close_glyph();
          end else begin
            ph = PH_A;
          end
        end
      endcase
    end
  endtask

  task automatic decode_beat(input in_item_t it);
    int k;
    beat_results = 0;
    if (it.glyph_start) begin
      box_x_q  = it.origin_x;
      box_y_q  = it.origin_y;
      hdr_skip = 1'b1;
      skip_cnt = 0;
      acc      = '0;
      fill     = 0;
    end
    if (hdr_skip) begin
      skip_cnt = (skip_cnt + 1) % 4;
      if (skip_cnt >= SKIP_BYTES) begin
        skip_cnt = 0;
        hdr_skip = 1'b0;
        ph       = PH_W;
        acc      = '0;
        fill     = 0;
      end
    end else begin
      for (k = 0; k < 8; k++) begin
        settle_fields();
        if (ph == PH_DONE) break;
        if (fill < 8) begin
          acc[fill] = it.data_byte[k];
          fill++;
        end
        settle_fields();
        if (ph == PH_DONE) break;
      end
    end
  endtask

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("error at %0t: %s", $time, msg);
  endtask

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("kind=%0d box=(%h,%h) w=%0d start=(%0d,%0d) len=%0d adv=%0d last=%0d",
                     r.kind, r.box_x, r.box_y, r.glyph_w, r.start_x, r.start_y,
                     r.run_length, r.advance, r.last);
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      log_error({"unexpected result ", fmt_result(got)});
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind || got.box_x !== want.box_x || got.box_y !== want.box_y ||
        got.glyph_w !== want.glyph_w || got.start_x !== want.start_x ||
        got.start_y !== want.start_y || got.run_length !== want.run_length ||
        got.advance !== want.advance || got.last !== want.last)
      log_error({"expected ", fmt_result(want), " got ", fmt_result(got)});
  endtask

  // monitor: every handshake is taken at the rising edge
  always @(posedge clk) begin
    in_fired  = rst_n && in_valid && in_ready;
    out_fired = rst_n && out_valid && out_ready;
    cfg_fired = rst_n && cfg_valid && cfg_ready;
    if (cfg_fired) begin
      case (cfg_index)
        CFG_ZERO_RUN_BITS: cfg_q.zero_run_bits = cfg_data;
        CFG_ONE_RUN_BITS:  cfg_q.one_run_bits  = cfg_data;
        CFG_WIDTH_BITS:    cfg_q.width_bits    = cfg_data;
        CFG_HEIGHT_BITS:   cfg_q.height_bits   = cfg_data;
        CFG_XOFF_BITS:     cfg_q.xoff_bits     = cfg_data;
        CFG_YOFF_BITS:     cfg_q.yoff_bits     = cfg_data;
        CFG_ADVANCE_BITS:  cfg_q.advance_bits  = cfg_data;
        CFG_HINT_MODE:     cfg_q.hint_mode     = cfg_data[0];
        default: ;
      endcase
    end
    if (in_fired) begin
      decode_beat(in_item);
      beats_taken++;
    end
    if (out_fired) check_result(out_item);
  end

  // driver: a held beat stays until taken, a new one may follow a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (record_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= record_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic gs, input logic [15:0] ox,
                           input logic [15:0] oy);
    in_item_t it;
    it.data_byte   = b;
    it.glyph_start = gs;
    it.origin_x    = ox;
    it.origin_y    = oy;
    record_bytes.push_back(it);
    beats_queued++;
  endtask

  // the flagged beat and the dropped beat after it
  task automatic start_record(input logic flagged, input logic [15:0] ox, input logic [15:0] oy);
    bitstream.delete();
    push_byte(8'($urandom), flagged, ox, oy);
    push_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
    record_beats += 2;
  endtask

  task automatic put_bits(input int value, input int nbits);
    int k;
    for (k = 0; k < nbits; k++) bitstream.push_back(value[k]);
  endtask

  task automatic put_header(input int w, input int h, input int xr, input int yr, input int ar);
    put_bits(w, field_len(cfg_q.width_bits));
    put_bits(h, field_len(cfg_q.height_bits));
    put_bits(xr, field_len(cfg_q.xoff_bits));
    put_bits(yr, field_len(cfg_q.yoff_bits));
    put_bits(ar, field_len(cfg_q.advance_bits));
  endtask

  task automatic put_pair(input int bg, input int fg);
    put_bits(bg, field_len(cfg_q.zero_run_bits));
    put_bits(fg, field_len(cfg_q.one_run_bits));
  endtask

  // pack bits lsb first, random padding, at least one byte; then ignored trailing beats
  task automatic flush_record(input int trailing);
    logic [7:0] b;
    bit first;
    int k;
    first = 1'b1;
    while (first || bitstream.size() != 0) begin
      first = 1'b0;
      b = 8'($urandom);
      for (k = 0; k < 8; k++)
        if (bitstream.size() != 0) b[k] = bitstream.pop_front();
      push_byte(b, 1'b0, 16'($urandom), 16'($urandom));
      record_beats++;
    end
    repeat (trailing) push_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
  endtask

  // mostly small values, now and then the full field range
  function automatic int pick_field(input int nbits, input int cap);
    int top;
    top = (1 << nbits) - 1;
    if (top <= cap || $urandom_range(3) == 0) return $urandom_range(top);
    return $urandom_range(cap);
  endfunction

  // stimulus side position tracking, only to know where a glyph may end
  function automatic void walk(inout int col, inout int row, input int len, input int w);
    int total;
    if (len == 0 || w == 0) return;
    total = col + len;
    row = row + total / w;
    if (row > 255) row = 255;
    col = total % w;
  endfunction

  task automatic random_glyph();
    int w, h, col, row, bg, fg, step;
    bit need_pair, rep, ended;
    // line noise ahead of the record now and then
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(3, 1))
        push_byte(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    start_record(1'b1, 16'($urandom), 16'($urandom));
    w = pick_field(field_len(cfg_q.width_bits), 10);
    h = pick_field(field_len(cfg_q.height_bits), 5);
    put_header(w, h, $urandom, $urandom, $urandom);
    col = 0;
    row = 0;
    bg = 0;
    fg = 0;
    need_pair = 1'b1;
    ended = (w == 0);
    for (step = 0; step < MAX_STEPS && !ended; step++) begin
      if (need_pair) begin
        bg = $urandom_range((1 << field_len(cfg_q.zero_run_bits)) - 1);
        fg = $urandom_range((1 << field_len(cfg_q.one_run_bits)) - 1);
        put_pair(bg, fg);
        walk(col, row, bg, w);
        walk(col, row, fg, w);
      end
      // past the last row keep replaying once in a while to push the row further
      rep = (row >= h) ? ($urandom_range(4) == 0) : ($urandom_range(2) == 0);
      put_bits(rep, 1);
      if (rep) begin
        walk(col, row, bg, w);
        walk(col, row, fg, w);
        need_pair = 1'b0;
      end else if (row >= h) begin
        ended = 1'b1;
      end else begin
        need_pair = 1'b1;
      end
    end
    // broken record: cut short, the next glyph start recovers
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(bitstream.size())) void'(bitstream.pop_back());
    flush_record(ended ? $urandom_range(2) : 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_fired) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(input int zb, input int ob, input int wb, input int hb,
                              input int xb, input int yb, input int ab, input bit hint);
    write_reg(CFG_ZERO_RUN_BITS, 4'(zb));
    write_reg(CFG_ONE_RUN_BITS, 4'(ob));
    write_reg(CFG_WIDTH_BITS, 4'(wb));
    write_reg(CFG_HEIGHT_BITS, 4'(hb));
    write_reg(CFG_XOFF_BITS, 4'(xb));
    write_reg(CFG_YOFF_BITS, 4'(yb));
    write_reg(CFG_ADVANCE_BITS, 4'(ab));
    // upper data bits must not matter for hint mode
    write_reg(CFG_HINT_MODE, {3'($urandom), hint});
  endtask

  // all beats taken, all results out, then let the back end finish silent bytes
  task automatic wait_idle();
    while (beats_taken != beats_queued || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 73; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 73; end
      default: begin in_idle_pct = 34; out_stall_pct = 34; end
    endcase
  endtask

  initial begin
    int phase_i, mark;
    set_idling(0);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset field widths
    // bytes before any glyph start: header skip from reset, origin zero,
    // raw offsets at both ends, replayed pair with an empty background run,
    // then a byte after the end that must be ignored
    start_record(1'b0, 16'($urandom), 16'($urandom));
    put_header(3, 2, 0, 15, 0);
    put_pair(0, 3);
    put_bits(1, 1);
    put_bits(0, 1);
    flush_record(1);
    // all-ones header fields at the top of the coordinate range, zero height
    start_record(1'b1, 16'hFFFF, 16'hFFFF);
    put_header(31, 0, 15, 15, 31);
    put_pair(15, 15);
    put_bits(0, 1);
    flush_record(0);
    // zero width ends right after the advance field
    start_record(1'b1, 16'h0000, 16'h0000);
    put_header(0, 31, 8, 8, 16);
    flush_record(0);
    // one column wide, replays drive the row into saturation
    start_record(1'b1, 16'($urandom), 16'($urandom));
    put_header(1, 1, 7, 0, 1);
    put_pair(15, 15);
    repeat (9) put_bits(1, 1);
    put_bits(0, 1);
    flush_record(1);

    for (phase_i = 1; phase_i <= PHASE_COUNT; phase_i++) begin
      wait_idle();
      case (phase_i)
        1: apply_config(4, 4, 5, 5, 4, 4, 5, 1'b1);
        2: apply_config(8, 8, 8, 8, 8, 8, 8, 1'b1);
        3: apply_config(0, 0, 0, 0, 0, 0, 0, 1'b0);
        4: apply_config(15, 15, 15, 15, 15, 15, 15, 1'b0);
        5: apply_config(0, 3, 3, 2, 0, 8, 1, 1'b1);
        6: apply_config(2, 2, 3, 3, 1, 1, 2, 1'b0);
        7: apply_config($urandom_range(15), $urandom_range(15), $urandom_range(15),
                        $urandom_range(15), $urandom_range(15), $urandom_range(15),
                        $urandom_range(15), 1'($urandom));
        default: apply_config(4, 4, 5, 5, 4, 4, 5, 1'b0);
      endcase
      if (phase_i == 3 || phase_i == 7)
        write_reg(4'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), 4'($urandom));
      set_idling(phase_i % 4);
      mark = record_beats;
      while (record_beats - mark < PHASE_BEATS) random_glyph();
    end

    wait_idle();
    if (due_results.size() != 0) log_error("results still outstanding at the end");
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
